// File: sv/lci_pkg.sv
package lci_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int RAD_W     = 31;
   localparam int A_W       = 64;
   localparam int WM_W      = 63;
   localparam int D_W       = 126;
   localparam int ROOT_W    = 63;
   localparam int PROD_W    = 95;
   localparam int NUM_W     = 98;
   localparam int MAG_W     = 97;
   localparam int Q_W       = 41;
   localparam int DIV_CMP_W = A_W + Q_W;

   localparam logic [Q_W:0] Q_LIMIT = (Q_W + 1)'(1) << (Q_W - 1);

   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1) << FRAC_BITS;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_RADIUS   = 2'd2;

   typedef enum logic [1:0] {
      ST_TWO     = 2'd0,
      ST_TANGENT = 2'd1,
      ST_NONE    = 2'd2,
      ST_DEGEN   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] nw;
      logic signed [NUM_W-1:0] mw;
      logic [COORD_W-1:0]      nxa;
      logic [COORD_W-1:0]      nya;
      logic                    nx_neg;
      logic                    ny_neg;
      logic [A_W-1:0]          a;
      status_type              status;
   } side_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      status_type                status;
   } result_type;

endpackage

// File: sv/lci_front.sv
module lci_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  logic signed [31:0]       normal_x,
   input  logic signed [31:0]       normal_y,
   input  logic signed [31:0]       point_x,
   input  logic signed [31:0]       point_y,
   input  logic signed [31:0]       center_x,
   input  logic signed [31:0]       center_y,
   input  logic [30:0]              radius,
   output logic                     out_valid,
   output logic [lci_pkg::D_W-1:0]  disc,
   output lci_pkg::side_type        side
);

   // Stage 1: offsets from the centre and magnitudes of the normal.
   logic               v1_ff;
   logic signed [31:0] nx1_ff, ny1_ff;
   logic signed [32:0] dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic [31:0]        nxa1_ff, nya1_ff, nxa1_in, nya1_in;
   logic               deg1_ff;

   always_comb begin
      dx1_in  = 33'(point_x) - 33'(center_x);
      dy1_in  = 33'(point_y) - 33'(center_y);
      nxa1_in = normal_x[31] ? 32'(-normal_x) : 32'(normal_x);
      nya1_in = normal_y[31] ? 32'(-normal_y) : 32'(normal_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         nx1_ff  <= normal_x;
         ny1_ff  <= normal_y;
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         nxa1_ff <= nxa1_in;
         nya1_ff <= nya1_in;
         deg1_ff <= (normal_y == 32'sd0);
      end
   end

   // Stage 2: dot product terms, squared normal and squared radius.
   logic               v2_ff;
   logic signed [64:0] pxd2_ff, pyd2_ff;
   logic [62:0]        nx2_ff, ny2_ff;
   logic [61:0]        r2_2_ff;
   logic [63:0]        nxsq2, nysq2, rsq2;
   logic [31:0]        nxa2_ff, nya2_ff;
   logic               nxn2_ff, nyn2_ff, deg2_ff;

   always_comb begin
      nxsq2 = 64'(nxa1_ff) * 64'(nxa1_ff);
      nysq2 = 64'(nya1_ff) * 64'(nya1_ff);
      rsq2  = 64'(radius) * 64'(radius);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         pxd2_ff <= 65'(nx1_ff) * 65'(dx1_ff);
         pyd2_ff <= 65'(ny1_ff) * 65'(dy1_ff);
         nx2_ff  <= nxsq2[62:0];
         ny2_ff  <= nysq2[62:0];
         r2_2_ff <= rsq2[61:0];
         nxa2_ff <= nxa1_ff;
         nya2_ff <= nya1_ff;
         nxn2_ff <= nx1_ff[31];
         nyn2_ff <= ny1_ff[31];
         deg2_ff <= deg1_ff;
      end
   end

   // Stage 3: w = n.d, its magnitude, and A = |n|^2.
   logic               v3_ff;
   logic signed [65:0] w3;
   logic [65:0]        wabs3;
   logic [lci_pkg::WM_W-1:0] wm3_ff;
   logic               wneg3_ff, big3_ff;
   logic [63:0]        a3_ff;
   logic [61:0]        r2_3_ff;
   logic [31:0]        nxa3_ff, nya3_ff;
   logic               nxn3_ff, nyn3_ff, deg3_ff;

   always_comb begin
      w3    = 66'(pxd2_ff) + 66'(pyd2_ff);
      wabs3 = w3[65] ? 66'(-w3) : 66'(w3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         wm3_ff   <= wabs3[62:0];
         wneg3_ff <= w3[65];
         big3_ff  <= |wabs3[65:63];
         a3_ff    <= 64'(nx2_ff) + 64'(ny2_ff);
         r2_3_ff  <= r2_2_ff;
         nxa3_ff  <= nxa2_ff;
         nya3_ff  <= nya2_ff;
         nxn3_ff  <= nxn2_ff;
         nyn3_ff  <= nyn2_ff;
         deg3_ff  <= deg2_ff;
      end
   end

   // Stage 4: partial products of A*r^2, w^2, |nx|*|w| and |ny|*|w| from 32- and 31-bit halves.
   logic               v4_ff;
   logic [62:0]        pll4_ff, plh4_ff, phl4_ff, phh4_ff;
   logic [63:0]        qll4_ff;
   logic [62:0]        qlh4_ff;
   logic [61:0]        qhh4_ff;
   logic [63:0]        nl4_ff, ml4_ff;
   logic [62:0]        nh4_ff, mh4_ff;
   logic [63:0]        a4_ff;
   logic [31:0]        nxa4_ff, nya4_ff;
   logic               nxn4_ff, nyn4_ff, nwn4_ff, mwn4_ff, deg4_ff, big4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         pll4_ff <= 63'(64'(a3_ff[31:0])  * 64'(r2_3_ff[30:0]));
         plh4_ff <= 63'(64'(a3_ff[31:0])  * 64'(r2_3_ff[61:31]));
         phl4_ff <= 63'(64'(a3_ff[63:32]) * 64'(r2_3_ff[30:0]));
         phh4_ff <= 63'(64'(a3_ff[63:32]) * 64'(r2_3_ff[61:31]));
         qll4_ff <= 64'(wm3_ff[31:0]) * 64'(wm3_ff[31:0]);
         qlh4_ff <= 63'(64'(wm3_ff[31:0]) * 64'(wm3_ff[62:32]));
         qhh4_ff <= 62'(64'(wm3_ff[62:32]) * 64'(wm3_ff[62:32]));
         nl4_ff  <= 64'(nxa3_ff) * 64'(wm3_ff[31:0]);
         nh4_ff  <= 63'(64'(nxa3_ff) * 64'(wm3_ff[62:32]));
         ml4_ff  <= 64'(nya3_ff) * 64'(wm3_ff[31:0]);
         mh4_ff  <= 63'(64'(nya3_ff) * 64'(wm3_ff[62:32]));
         a4_ff   <= a3_ff;
         nxa4_ff <= nxa3_ff;
         nya4_ff <= nya3_ff;
         nxn4_ff <= nxn3_ff;
         nyn4_ff <= nyn3_ff;
         nwn4_ff <= nxn3_ff ^ wneg3_ff;
         mwn4_ff <= nyn3_ff ^ wneg3_ff;
         deg4_ff <= deg3_ff;
         big4_ff <= big3_ff;
      end
   end

   // Stage 5: partial products summed into full-width values.
   logic               v5_ff;
   logic [lci_pkg::D_W-1:0]    ar5_ff, w2_5_ff;
   logic [lci_pkg::PROD_W-1:0] nwm5_ff, mwm5_ff;
   logic [63:0]        a5_ff;
   logic [31:0]        nxa5_ff, nya5_ff;
   logic               nxn5_ff, nyn5_ff, nwn5_ff, mwn5_ff, deg5_ff, big5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         ar5_ff  <= lci_pkg::D_W'(pll4_ff) + (lci_pkg::D_W'(plh4_ff) << 31)
                  + (lci_pkg::D_W'(phl4_ff) << 32) + (lci_pkg::D_W'(phh4_ff) << 63);
         w2_5_ff <= lci_pkg::D_W'(qll4_ff) + (lci_pkg::D_W'(qlh4_ff) << 33)
                  + (lci_pkg::D_W'(qhh4_ff) << 64);
         nwm5_ff <= lci_pkg::PROD_W'(nl4_ff) + (lci_pkg::PROD_W'(nh4_ff) << 32);
         mwm5_ff <= lci_pkg::PROD_W'(ml4_ff) + (lci_pkg::PROD_W'(mh4_ff) << 32);
         a5_ff   <= a4_ff;
         nxa5_ff <= nxa4_ff;
         nya5_ff <= nya4_ff;
         nxn5_ff <= nxn4_ff;
         nyn5_ff <= nyn4_ff;
         nwn5_ff <= nwn4_ff;
         mwn5_ff <= mwn4_ff;
         deg5_ff <= deg4_ff;
         big5_ff <= big4_ff;
      end
   end

   // Stage 6: discriminant, case selection and signed foot numerators.
   logic                      v6_ff;
   logic signed [lci_pkg::D_W:0] dsub6;
   logic [lci_pkg::D_W-1:0]   disc6_ff;
   lci_pkg::side_type         side6_in, side6_ff;
   logic signed [lci_pkg::NUM_W-1:0] nwp6, mwp6;

   always_comb begin
      dsub6 = $signed({1'b0, ar5_ff}) - $signed({1'b0, w2_5_ff});
      nwp6  = $signed(lci_pkg::NUM_W'(nwm5_ff));
      mwp6  = $signed(lci_pkg::NUM_W'(mwm5_ff));
      side6_in.nw     = nwn5_ff ? -nwp6 : nwp6;
      side6_in.mw     = mwn5_ff ? -mwp6 : mwp6;
      side6_in.nxa    = nxa5_ff;
      side6_in.nya    = nya5_ff;
      side6_in.nx_neg = nxn5_ff;
      side6_in.ny_neg = nyn5_ff;
      side6_in.a      = a5_ff;
      if (deg5_ff) begin
         side6_in.status = lci_pkg::ST_DEGEN;
      end else if (big5_ff || dsub6[lci_pkg::D_W]) begin
         side6_in.status = lci_pkg::ST_NONE;
      end else if (dsub6 == '0) begin
         side6_in.status = lci_pkg::ST_TANGENT;
      end else begin
         side6_in.status = lci_pkg::ST_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         disc6_ff <= dsub6[lci_pkg::D_W-1:0];
         side6_ff <= side6_in;
      end
   end

   assign out_valid = v6_ff;
   assign disc      = disc6_ff;
   assign side      = side6_ff;

endmodule

// File: sv/lci_sqrt.sv
module lci_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  logic [lci_pkg::D_W-1:0]    disc,
   input  lci_pkg::side_type          side_in,
   output logic                       out_valid,
   output logic [lci_pkg::ROOT_W-1:0] root,
   output lci_pkg::side_type          side_out
);

   // One root bit per stage, restoring digit-by-digit method on bit pairs.
   logic                        v_ff    [lci_pkg::ROOT_W];
   logic [lci_pkg::ROOT_W+2:0]  rem_ff  [lci_pkg::ROOT_W];
   logic [lci_pkg::ROOT_W-1:0]  root_ff [lci_pkg::ROOT_W];
   logic [lci_pkg::D_W-1:0]     dsh_ff  [lci_pkg::ROOT_W];
   lci_pkg::side_type           side_ff [lci_pkg::ROOT_W];

   for (genvar k = 0; k < lci_pkg::ROOT_W; k++) begin : g_step
      logic                       v_p;
      logic [lci_pkg::ROOT_W+2:0] rem_p, cur, trial;
      logic [lci_pkg::ROOT_W-1:0] root_p;
      logic [lci_pkg::D_W-1:0]    dsh_p;
      lci_pkg::side_type          side_p;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign dsh_p  = disc;
         assign side_p = side_in;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign dsh_p  = dsh_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign cur   = {rem_p[lci_pkg::ROOT_W:0], dsh_p[lci_pkg::D_W-1 -: 2]};
      assign trial = {1'b0, root_p, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_p;
         end
         if (adv) begin
            if (cur >= trial) begin
               rem_ff[k]  <= cur - trial;
               root_ff[k] <= {root_p[lci_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= cur;
               root_ff[k] <= {root_p[lci_pkg::ROOT_W-2:0], 1'b0};
            end
            dsh_ff[k]  <= dsh_p << 2;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = v_ff[lci_pkg::ROOT_W-1];
   assign root      = root_ff[lci_pkg::ROOT_W-1];
   assign side_out  = side_ff[lci_pkg::ROOT_W-1];

endmodule

// File: sv/lci_div.sv
module lci_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            adv,
   input  logic                            in_valid,
   input  logic signed [lci_pkg::NUM_W-1:0] num,
   input  logic [lci_pkg::A_W-1:0]         a,
   input  lci_pkg::status_type             status_in,
   input  logic signed [31:0]              center,
   output logic                            out_valid,
   output logic signed [31:0]              coord,
   output lci_pkg::status_type             status_out
);

   // Stage 0: sign and magnitude.
   logic                        v0_ff, neg0_ff;
   logic [lci_pkg::MAG_W-1:0]   mag0_ff;
   logic [lci_pkg::A_W-1:0]     a0_ff;
   lci_pkg::status_type         st0_ff;
   logic signed [lci_pkg::NUM_W-1:0] negnum;

   assign negnum = -num;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= in_valid;
      end
      if (adv) begin
         neg0_ff <= num[lci_pkg::NUM_W-1];
         mag0_ff <= num[lci_pkg::NUM_W-1] ? negnum[lci_pkg::MAG_W-1:0]
                                          : num[lci_pkg::MAG_W-1:0];
         a0_ff   <= a;
         st0_ff  <= status_in;
      end
   end

   // Stage 1: a quotient that would need more bits than kept saturates anyway.
   logic                        v1_ff, neg1_ff, ovf1_ff;
   logic [lci_pkg::A_W-1:0]     rem1_ff, a1_ff;
   logic [lci_pkg::Q_W-1:0]     low1_ff;
   lci_pkg::status_type         st1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
      end
      if (adv) begin
         neg1_ff <= neg0_ff;
         ovf1_ff <= lci_pkg::DIV_CMP_W'(mag0_ff) >= {a0_ff, lci_pkg::Q_W'(0)};
         rem1_ff <= lci_pkg::A_W'(mag0_ff[lci_pkg::MAG_W-1:lci_pkg::Q_W]);
         low1_ff <= mag0_ff[lci_pkg::Q_W-1:0];
         a1_ff   <= a0_ff;
         st1_ff  <= st0_ff;
      end
   end

   // Restoring long division, one quotient bit per stage.
   logic                        v_ff    [lci_pkg::Q_W];
   logic                        neg_ff  [lci_pkg::Q_W];
   logic                        ovf_ff  [lci_pkg::Q_W];
   logic [lci_pkg::A_W-1:0]     rem_ff  [lci_pkg::Q_W];
   logic [lci_pkg::A_W-1:0]     a_ff    [lci_pkg::Q_W];
   logic [lci_pkg::Q_W-1:0]     low_ff  [lci_pkg::Q_W];
   logic [lci_pkg::Q_W-1:0]     q_ff    [lci_pkg::Q_W];
   lci_pkg::status_type         st_ff   [lci_pkg::Q_W];

   for (genvar k = 0; k < lci_pkg::Q_W; k++) begin : g_step
      logic                      v_p, neg_p, ovf_p, ge;
      logic [lci_pkg::A_W-1:0]   rem_p, a_p;
      logic [lci_pkg::A_W:0]     cur, diff;
      logic [lci_pkg::Q_W-1:0]   low_p, q_p;
      lci_pkg::status_type       st_p;

      if (k == 0) begin : g_first
         assign v_p   = v1_ff;
         assign neg_p = neg1_ff;
         assign ovf_p = ovf1_ff;
         assign rem_p = rem1_ff;
         assign a_p   = a1_ff;
         assign low_p = low1_ff;
         assign q_p   = '0;
         assign st_p  = st1_ff;
      end else begin : g_next
         assign v_p   = v_ff[k-1];
         assign neg_p = neg_ff[k-1];
         assign ovf_p = ovf_ff[k-1];
         assign rem_p = rem_ff[k-1];
         assign a_p   = a_ff[k-1];
         assign low_p = low_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign st_p  = st_ff[k-1];
      end

      assign cur  = {rem_p, low_p[lci_pkg::Q_W-1]};
      assign diff = cur - {1'b0, a_p};
      assign ge   = cur >= {1'b0, a_p};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_p;
         end
         if (adv) begin
            rem_ff[k] <= ge ? diff[lci_pkg::A_W-1:0] : cur[lci_pkg::A_W-1:0];
            q_ff[k]   <= {q_p[lci_pkg::Q_W-2:0], ge};
            low_ff[k] <= low_p << 1;
            neg_ff[k] <= neg_p;
            ovf_ff[k] <= ovf_p;
            a_ff[k]   <= a_p;
            st_ff[k]  <= st_p;
         end
      end
   end

   // Round half away from zero on the magnitude.
   logic                        vr_ff, negr_ff, ovfr_ff, rnd;
   logic [lci_pkg::Q_W:0]       qr_ff;
   lci_pkg::status_type         str_ff;

   assign rnd = {rem_ff[lci_pkg::Q_W-1], 1'b0} >= {1'b0, a_ff[lci_pkg::Q_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (adv) begin
         vr_ff <= v_ff[lci_pkg::Q_W-1];
      end
      if (adv) begin
         qr_ff   <= (lci_pkg::Q_W + 1)'(q_ff[lci_pkg::Q_W-1]) + (lci_pkg::Q_W + 1)'(rnd);
         negr_ff <= neg_ff[lci_pkg::Q_W-1];
         ovfr_ff <= ovf_ff[lci_pkg::Q_W-1];
         str_ff  <= st_ff[lci_pkg::Q_W-1];
      end
   end

   // Add the centre and saturate to the coordinate range.
   logic                     vo_ff;
   logic signed [31:0]       coord_ff, coord_in;
   lci_pkg::status_type      sto_ff;
   logic signed [43:0]       sq, sum;

   always_comb begin
      sq  = $signed({2'b00, qr_ff});
      sum = (negr_ff ? -sq : sq) + 44'(center);
      if (ovfr_ff || (qr_ff > lci_pkg::Q_LIMIT)) begin
         coord_in = negr_ff ? lci_pkg::COORD_MIN : lci_pkg::COORD_MAX;
      end else if (sum > 44'(lci_pkg::COORD_MAX)) begin
         coord_in = lci_pkg::COORD_MAX;
      end else if (sum < 44'(lci_pkg::COORD_MIN)) begin
         coord_in = lci_pkg::COORD_MIN;
      end else begin
         coord_in = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= vr_ff;
      end
      if (adv) begin
         coord_ff <= coord_in;
         sto_ff   <= str_ff;
      end
   end

   assign out_valid  = vo_ff;
   assign coord      = coord_ff;
   assign status_out = sto_ff;

endmodule

// File: sv/line_circle_intersection.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   normal_x, normal_y, point_x, point_y
// rsp       out        rsp_valid/rsp_ready   first_x, first_y, second_x, second_y, status
// csr       in         csr_we                csr_index, csr_wdata
//
// One item enters per cycle while the skid register is empty; each result passes the front
// end, the 63-stage square root and the dividers with their 41 quotient-bit stages.
// Reset clears all valid bits and sets the circle to the origin with unit radius.
// A result not taken waits in the output register; one more item lands in a skid
// register, and the whole pipeline then holds until the output drains.
module line_circle_intersection (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_normal_x,
   input  logic signed [31:0] req_normal_y,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_first_x,
   output logic signed [31:0] rsp_first_y,
   output logic signed [31:0] rsp_second_x,
   output logic signed [31:0] rsp_second_y,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   // Circle registers.
   logic signed [31:0] center_x_ff, center_y_ff;
   logic [30:0]        radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= lci_pkg::RADIUS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lci_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            lci_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            lci_pkg::CSR_RADIUS:   radius_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   logic skid_valid_ff, rsp_valid_ff;
   logic adv;

   assign adv       = ~skid_valid_ff;
   assign req_ready = adv;

   logic                       fr_valid;
   logic [lci_pkg::D_W-1:0]    fr_disc;
   lci_pkg::side_type          fr_side;

   lci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .normal_x  (req_normal_x),
      .normal_y  (req_normal_y),
      .point_x   (req_point_x),
      .point_y   (req_point_y),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .radius    (radius_ff),
      .out_valid (fr_valid),
      .disc      (fr_disc),
      .side      (fr_side)
   );

   logic                        sq_valid;
   logic [lci_pkg::ROOT_W-1:0]  sq_root;
   lci_pkg::side_type           sq_side;

   lci_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .disc      (fr_disc),
      .side_in   (fr_side),
      .out_valid (sq_valid),
      .root      (sq_root),
      .side_out  (sq_side)
   );

   // N1: partial products of |ny|*S and |nx|*S.
   logic               vn1_ff;
   logic [63:0]        pl1_ff, tl1_ff;
   logic [62:0]        ph1_ff, th1_ff;
   logic               tneg1_ff;
   lci_pkg::side_type  sn1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn1_ff <= 1'b0;
      end else if (adv) begin
         vn1_ff <= sq_valid;
      end
      if (adv) begin
         pl1_ff   <= 64'(sq_side.nya) * 64'(sq_root[31:0]);
         ph1_ff   <= 63'(64'(sq_side.nya) * 64'(sq_root[62:32]));
         tl1_ff   <= 64'(sq_side.nxa) * 64'(sq_root[31:0]);
         th1_ff   <= 63'(64'(sq_side.nxa) * 64'(sq_root[62:32]));
         tneg1_ff <= sq_side.nx_neg ^ sq_side.ny_neg;
         sn1_ff   <= sq_side;
      end
   end

   // N2: full products.
   logic                       vn2_ff, tneg2_ff;
   logic [lci_pkg::PROD_W-1:0] pm2_ff, tm2_ff;
   lci_pkg::side_type          sn2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vn2_ff <= 1'b0;
      end else if (adv) begin
         vn2_ff <= vn1_ff;
      end
      if (adv) begin
         pm2_ff   <= lci_pkg::PROD_W'(pl1_ff) + (lci_pkg::PROD_W'(ph1_ff) << 32);
         tm2_ff   <= lci_pkg::PROD_W'(tl1_ff) + (lci_pkg::PROD_W'(th1_ff) << 32);
         tneg2_ff <= tneg1_ff;
         sn2_ff   <= sn1_ff;
      end
   end

   // N3: the four numerators; the sign of t picks add or subtract.
   logic                             vn3_ff;
   logic signed [lci_pkg::NUM_W-1:0] n0_ff, n1_ff, n2_ff, n3_ff, pv, tv;
   logic [lci_pkg::A_W-1:0]          a3_ff;
   lci_pkg::status_type              st3_ff;

   assign pv = $signed(lci_pkg::NUM_W'(pm2_ff));
   assign tv = $signed(lci_pkg::NUM_W'(tm2_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         vn3_ff <= 1'b0;
      end else if (adv) begin
         vn3_ff <= vn2_ff;
      end
      if (adv) begin
         n0_ff  <= sn2_ff.nw + pv;
         n2_ff  <= sn2_ff.nw - pv;
         n1_ff  <= tneg2_ff ? sn2_ff.mw + tv : sn2_ff.mw - tv;
         n3_ff  <= tneg2_ff ? sn2_ff.mw - tv : sn2_ff.mw + tv;
         a3_ff  <= sn2_ff.a;
         st3_ff <= sn2_ff.status;
      end
   end

   logic                 dv_valid;
   lci_pkg::status_type  dv_status;
   logic signed [31:0]   c0, c1, c2, c3;

   lci_div u_div_fx (
      .clock (clock), .reset (reset), .adv (adv), .in_valid (vn3_ff),
      .num (n0_ff), .a (a3_ff), .status_in (st3_ff), .center (center_x_ff),
      .out_valid (dv_valid), .coord (c0), .status_out (dv_status)
   );

   lci_div u_div_fy (
      .clock (clock), .reset (reset), .adv (adv), .in_valid (vn3_ff),
      .num (n1_ff), .a (a3_ff), .status_in (st3_ff), .center (center_y_ff),
      .out_valid (), .coord (c1), .status_out ()
   );

   lci_div u_div_sx (
      .clock (clock), .reset (reset), .adv (adv), .in_valid (vn3_ff),
      .num (n2_ff), .a (a3_ff), .status_in (st3_ff), .center (center_x_ff),
      .out_valid (), .coord (c2), .status_out ()
   );

   lci_div u_div_sy (
      .clock (clock), .reset (reset), .adv (adv), .in_valid (vn3_ff),
      .num (n3_ff), .a (a3_ff), .status_in (st3_ff), .center (center_y_ff),
      .out_valid (), .coord (c3), .status_out ()
   );

   // Coordinates are zero when there is no point to report.
   lci_pkg::result_type pipe_res;
   logic                blank;

   always_comb begin
      blank = (dv_status == lci_pkg::ST_NONE) || (dv_status == lci_pkg::ST_DEGEN);
      pipe_res.first_x  = blank ? 32'sd0 : c0;
      pipe_res.first_y  = blank ? 32'sd0 : c1;
      pipe_res.second_x = blank ? 32'sd0 : c2;
      pipe_res.second_y = blank ? 32'sd0 : c3;
      pipe_res.status   = dv_status;
   end

   // Output register and skid register.
   lci_pkg::result_type rsp_ff, skid_ff;
   logic                rsp_free;

   assign rsp_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_free) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (dv_valid) begin
         if (rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_free) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_free) begin
            rsp_ff <= skid_ff;
         end
      end else if (dv_valid) begin
         if (rsp_free) begin
            rsp_ff <= pipe_res;
         end else begin
            skid_ff <= pipe_res;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_first_x  = rsp_ff.first_x;
   assign rsp_first_y  = rsp_ff.first_y;
   assign rsp_second_x = rsp_ff.second_x;
   assign rsp_second_y = rsp_ff.second_y;
   assign rsp_status   = rsp_ff.status;

   // The skid register only ever holds an item behind a waiting result.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid register filled while output was free");

   a_blank_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == lci_pkg::ST_NONE
                       || rsp_ff.status == lci_pkg::ST_DEGEN)
      |-> (rsp_ff.first_x == 32'sd0) && (rsp_ff.first_y == 32'sd0)
          && (rsp_ff.second_x == 32'sd0) && (rsp_ff.second_y == 32'sd0))
      else $error("coordinates not cleared without an intersection");

   a_tangent_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status == lci_pkg::ST_TANGENT)
      |-> (rsp_ff.first_x == rsp_ff.second_x) && (rsp_ff.first_y == rsp_ff.second_y))
      else $error("tangent item with two different points");

endmodule
